### sv/assert_macros.svh
// assertion macros shared by the rtl that checks itself
// every check samples on the rising edge of clk and is off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define NGLIF_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("nglif check failed");

// antecedent implies consequent (consequent may carry a fixed delay)
`define NGLIF_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("nglif check failed");

`endif

### sv/nglif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglif_pkg
// types, register codes and divide helpers for the neutral gcr / ink fade block
// ----------------------------------------------------------------------------
package nglif_pkg;

	localparam int TONE_W   = 8;
	localparam int PCT_W    = 7;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int PROD_W   = 2 * TONE_W;
	localparam int FADE_P_W = TONE_W + PCT_W;

	// floor(x/100) as (x * 5243) >> 19, exact for x up to 43000
	localparam int RECIP_W   = 13;
	localparam int FADE_SHIFT = 19;
	localparam logic [RECIP_W-1:0] FADE_RECIP = 13'd5243;
	localparam int FADE_Q_W  = FADE_P_W + RECIP_W;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// register map, word index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_GATE,
		REG_MAX_TONE,
		REG_STRENGTH,
		REG_GAIN,
		REG_FLOOR,
		REG_LC_FADE,
		REG_LM_FADE
	} reg_idx_t;

	// settings seen by the datapath, fade already clamped to a keep factor
	typedef struct packed {
		logic              enable;
		logic [TONE_W-1:0] gate;
		logic [TONE_W-1:0] max_tone;
		logic [TONE_W-1:0] strength;
		logic [TONE_W-1:0] gain;
		logic [TONE_W-1:0] black_floor;
		logic [PCT_W-1:0]  lc_keep;
		logic [PCT_W-1:0]  lm_keep;
	} cfg_t;

	// floor(x/255) for x up to 255*255: (x + (x>>8) + 1) >> 8
	function automatic logic [TONE_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] s;
		s = {1'b0, x} + {{(TONE_W+1){1'b0}}, x[PROD_W-1:TONE_W]} + {{PROD_W{1'b0}}, 1'b1};
		return s[PROD_W-1:TONE_W];
	endfunction

endpackage

### sv/neutral_gcr_light_ink_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neutral_gcr_light_ink_fade
// gray component replacement on near-neutral pixels with light ink fade
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  pixel in  start (busy always low)       cyan_in .. light_magenta_in, end_of_image
//  pixel out done, one cycle strobe        cyan_out .. light_magenta_out, end_of_image_out
//  config    apb psel/penable/pwrite       paddr[4:2] selects register, pwdata/prdata
//
//  one item enters every cycle; its result strobes on done after passing the
//  five register stages: detect, products, pull, black add, output
//  busy never rises; the receiver has no hold-off, so nothing stalls
//  reset clears the valid chain and loads register defaults; in-flight items are dropped
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module neutral_gcr_light_ink_fade
	import nglif_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [TONE_W-1:0] cyan_in,
	input  logic [TONE_W-1:0] magenta_in,
	input  logic [TONE_W-1:0] yellow_in,
	input  logic [TONE_W-1:0] black_in,
	input  logic [TONE_W-1:0] light_cyan_in,
	input  logic [TONE_W-1:0] light_magenta_in,
	input  logic              end_of_image,
	output logic              done,
	output logic [TONE_W-1:0] cyan_out,
	output logic [TONE_W-1:0] magenta_out,
	output logic [TONE_W-1:0] yellow_out,
	output logic [TONE_W-1:0] black_out,
	output logic [TONE_W-1:0] light_cyan_out,
	output logic [TONE_W-1:0] light_magenta_out,
	output logic              end_of_image_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [TONE_W-1:0] c_s1, m_s1, y_s1, k_s1, lc_s1, lm_s1, lo_s1;
	logic              apply_s1, eoi_s1;

	assign busy = 1'b0;

	// settings
	nglif_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// neutral detect
	nglif_detect u_detect (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start && !busy),
		.cyan          (cyan_in),
		.magenta       (magenta_in),
		.yellow        (yellow_in),
		.black         (black_in),
		.light_cyan    (light_cyan_in),
		.light_magenta (light_magenta_in),
		.eoi           (end_of_image),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.c_s1          (c_s1),
		.m_s1          (m_s1),
		.y_s1          (y_s1),
		.k_s1          (k_s1),
		.lc_s1         (lc_s1),
		.lm_s1         (lm_s1),
		.lo_s1         (lo_s1),
		.apply_s1      (apply_s1),
		.eoi_s1        (eoi_s1)
	);

	// replacement and fade datapath
	nglif_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.c_s1     (c_s1),
		.m_s1     (m_s1),
		.y_s1     (y_s1),
		.k_s1     (k_s1),
		.lc_s1    (lc_s1),
		.lm_s1    (lm_s1),
		.lo_s1    (lo_s1),
		.apply_s1 (apply_s1),
		.eoi_s1   (eoi_s1),
		.valid_s5 (done),
		.c_s5     (cyan_out),
		.m_s5     (magenta_out),
		.y_s5     (yellow_out),
		.k_s5     (black_out),
		.lc_s5    (light_cyan_out),
		.lm_s5    (light_magenta_out),
		.eoi_s5   (end_of_image_out)
	);

	// every accepted item comes out on done after the five register stages
	`NGLIF_IMPLY(a_latency, start && !busy, ##5 done)
	// replacement never adds ink to cyan and never takes black away
	`NGLIF_IMPLY(a_cmy_k_dir, done, (cyan_out <= $past(cyan_in, 5)) && (black_out >= $past(black_in, 5)))
	// fade never raises a light ink
	`NGLIF_IMPLY(a_fade_dir, done, (light_cyan_out <= $past(light_cyan_in, 5)) && (light_magenta_out <= $past(light_magenta_in, 5)))

endmodule

### sv/nglif_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglif_cfg
// apb register file holding the gcr and fade settings
// ----------------------------------------------------------------------------
module nglif_cfg
	import nglif_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic              enable_q;
	logic [TONE_W-1:0] gate_q;
	logic [TONE_W-1:0] max_tone_q;
	logic [TONE_W-1:0] strength_q;
	logic [TONE_W-1:0] gain_q;
	logic [TONE_W-1:0] floor_q;
	logic [PCT_W-1:0]  lc_pct_q;
	logic [PCT_W-1:0]  lm_pct_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			gate_q     <= 8'd14;
			max_tone_q <= 8'd180;
			strength_q <= 8'd160;
			gain_q     <= 8'd220;
			floor_q    <= 8'd6;
			lc_pct_q   <= 7'd70;
			lm_pct_q   <= 7'd50;
		end else if (wr_en) begin
			unique case (idx)
				REG_ENABLE:   enable_q   <= pwdata[0];
				REG_GATE:     gate_q     <= pwdata[TONE_W-1:0];
				REG_MAX_TONE: max_tone_q <= pwdata[TONE_W-1:0];
				REG_STRENGTH: strength_q <= pwdata[TONE_W-1:0];
				REG_GAIN:     gain_q     <= pwdata[TONE_W-1:0];
				REG_FLOOR:    floor_q    <= pwdata[TONE_W-1:0];
				REG_LC_FADE:  lc_pct_q   <= pwdata[PCT_W-1:0];
				REG_LM_FADE:  lm_pct_q   <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_ENABLE:   prdata[0]          = enable_q;
			REG_GATE:     prdata[TONE_W-1:0] = gate_q;
			REG_MAX_TONE: prdata[TONE_W-1:0] = max_tone_q;
			REG_STRENGTH: prdata[TONE_W-1:0] = strength_q;
			REG_GAIN:     prdata[TONE_W-1:0] = gain_q;
			REG_FLOOR:    prdata[TONE_W-1:0] = floor_q;
			REG_LC_FADE:  prdata[PCT_W-1:0]  = lc_pct_q;
			REG_LM_FADE:  prdata[PCT_W-1:0]  = lm_pct_q;
			default:      prdata = '0;
		endcase
	end

	// settings for the datapath, fade above 100 percent clamps to full fade
	always_comb begin
		cfg.enable      = enable_q;
		cfg.gate        = gate_q;
		cfg.max_tone    = max_tone_q;
		cfg.strength    = strength_q;
		cfg.gain        = gain_q;
		cfg.black_floor = floor_q;
		cfg.lc_keep     = (lc_pct_q > PCT_FULL) ? '0 : PCT_FULL - lc_pct_q;
		cfg.lm_keep     = (lm_pct_q > PCT_FULL) ? '0 : PCT_FULL - lm_pct_q;
	end

endmodule

### sv/nglif_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglif_detect
// first stage: cmy min/max and the near-neutral decision
// ----------------------------------------------------------------------------
module nglif_detect
	import nglif_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [TONE_W-1:0] cyan,
	input  logic [TONE_W-1:0] magenta,
	input  logic [TONE_W-1:0] yellow,
	input  logic [TONE_W-1:0] black,
	input  logic [TONE_W-1:0] light_cyan,
	input  logic [TONE_W-1:0] light_magenta,
	input  logic              eoi,
	input  cfg_t              cfg,
	output logic              valid_s1,
	output logic [TONE_W-1:0] c_s1,
	output logic [TONE_W-1:0] m_s1,
	output logic [TONE_W-1:0] y_s1,
	output logic [TONE_W-1:0] k_s1,
	output logic [TONE_W-1:0] lc_s1,
	output logic [TONE_W-1:0] lm_s1,
	output logic [TONE_W-1:0] lo_s1,
	output logic              apply_s1,
	output logic              eoi_s1
);

	logic [TONE_W-1:0] hi;
	logic [TONE_W-1:0] lo;
	logic              apply;

	// spread and gate checks
	always_comb begin
		hi = cyan;
		lo = cyan;
		if (magenta > hi) hi = magenta;
		if (yellow > hi)  hi = yellow;
		if (magenta < lo) lo = magenta;
		if (yellow < lo)  lo = yellow;
		apply = cfg.enable && ((hi - lo) <= cfg.gate) && (hi <= cfg.max_tone);
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		c_s1     <= cyan;
		m_s1     <= magenta;
		y_s1     <= yellow;
		k_s1     <= black;
		lc_s1    <= light_cyan;
		lm_s1    <= light_magenta;
		lo_s1    <= lo;
		apply_s1 <= apply;
		eoi_s1   <= eoi;
	end

endmodule

### sv/nglif_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglif_mix
// stages two to five: pull and fade products, cmy pull, black add and floor
// ----------------------------------------------------------------------------
module nglif_mix
	import nglif_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              valid_s1,
	input  logic [TONE_W-1:0] c_s1,
	input  logic [TONE_W-1:0] m_s1,
	input  logic [TONE_W-1:0] y_s1,
	input  logic [TONE_W-1:0] k_s1,
	input  logic [TONE_W-1:0] lc_s1,
	input  logic [TONE_W-1:0] lm_s1,
	input  logic [TONE_W-1:0] lo_s1,
	input  logic              apply_s1,
	input  logic              eoi_s1,
	output logic              valid_s5,
	output logic [TONE_W-1:0] c_s5,
	output logic [TONE_W-1:0] m_s5,
	output logic [TONE_W-1:0] y_s5,
	output logic [TONE_W-1:0] k_s5,
	output logic [TONE_W-1:0] lc_s5,
	output logic [TONE_W-1:0] lm_s5,
	output logic              eoi_s5
);

	// stage 2
	logic                valid_s2;
	logic [PROD_W-1:0]   pullp_s2;
	logic [FADE_P_W-1:0] lcp_s2, lmp_s2;
	logic [TONE_W-1:0]   c_s2, m_s2, y_s2, k_s2, lc_s2, lm_s2;
	logic                apply_s2, nz_s2, eoi_s2;
	// stage 3
	logic                valid_s3;
	logic [TONE_W-1:0]   pull_s3;
	logic [FADE_Q_W-1:0] lcq_s3, lmq_s3;
	logic [TONE_W-1:0]   c_s3, m_s3, y_s3, k_s3, lc_s3, lm_s3;
	logic                apply_s3, nz_s3, eoi_s3;
	// stage 4
	logic                valid_s4;
	logic [PROD_W-1:0]   addp_s4;
	logic [TONE_W-1:0]   c_s4, m_s4, y_s4, k_s4, lc_s4, lm_s4;
	logic                floor_en_s4, eoi_s4;
	// stage 5 logic
	logic [TONE_W-1:0]   add;
	logic [TONE_W:0]     ksum;
	logic [TONE_W-1:0]   ksat;
	logic [TONE_W-1:0]   pull;

	assign pull = apply_s2 ? div255(pullp_s2) : '0;

	// black add, saturate and floor
	always_comb begin
		add  = div255(addp_s4);
		ksum = {1'b0, k_s4} + {1'b0, add};
		ksat = ksum[TONE_W] ? {TONE_W{1'b1}} : ksum[TONE_W-1:0];
		if (floor_en_s4 && (ksat < cfg.black_floor)) ksat = cfg.black_floor;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 2: pull product and fade products
	always_ff @(posedge clk) begin
		pullp_s2 <= lo_s1 * cfg.strength;
		lcp_s2   <= lc_s1 * cfg.lc_keep;
		lmp_s2   <= lm_s1 * cfg.lm_keep;
		c_s2     <= c_s1;
		m_s2     <= m_s1;
		y_s2     <= y_s1;
		k_s2     <= k_s1;
		lc_s2    <= lc_s1;
		lm_s2    <= lm_s1;
		apply_s2 <= apply_s1;
		nz_s2    <= (lo_s1 != '0);
		eoi_s2   <= eoi_s1;
	end

	// stage 3: pull off cmy, fade reciprocal products
	always_ff @(posedge clk) begin
		pull_s3  <= pull;
		c_s3     <= c_s2 - pull;
		m_s3     <= m_s2 - pull;
		y_s3     <= y_s2 - pull;
		lcq_s3   <= lcp_s2 * FADE_RECIP;
		lmq_s3   <= lmp_s2 * FADE_RECIP;
		k_s3     <= k_s2;
		lc_s3    <= lc_s2;
		lm_s3    <= lm_s2;
		apply_s3 <= apply_s2;
		nz_s3    <= nz_s2;
		eoi_s3   <= eoi_s2;
	end

	// stage 4: black add product, faded light inks
	always_ff @(posedge clk) begin
		addp_s4     <= pull_s3 * cfg.gain;
		lc_s4       <= apply_s3 ? lcq_s3[FADE_SHIFT+TONE_W-1:FADE_SHIFT] : lc_s3;
		lm_s4       <= apply_s3 ? lmq_s3[FADE_SHIFT+TONE_W-1:FADE_SHIFT] : lm_s3;
		c_s4        <= c_s3;
		m_s4        <= m_s3;
		y_s4        <= y_s3;
		k_s4        <= k_s3;
		floor_en_s4 <= apply_s3 && nz_s3;
		eoi_s4      <= eoi_s3;
	end

	// stage 5: result register
	always_ff @(posedge clk) begin
		c_s5   <= c_s4;
		m_s5   <= m_s4;
		y_s5   <= y_s4;
		k_s5   <= ksat;
		lc_s5  <= lc_s4;
		lm_s5  <= lm_s4;
		eoi_s5 <= eoi_s4;
	end

endmodule

### tb/tb_neutral_gcr_light_ink_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neutral_gcr_light_ink_fade
// self-checking bench for the neutral gcr / light ink fade pixel block:
// pixels go in on start/busy and results come back on the done strobe.
// A scoreboard computes each expected pixel from its own copy of the
// register settings. The bench runs directed corner pixels, then random
// setting phases with mostly near-neutral pixels and random gaps.
// ----------------------------------------------------------------------------

module tb_neutral_gcr_light_ink_fade;
	import nglif_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int REPORT_CAP   = 40;

	// one pixel, input and result share the layout
	typedef struct packed {
		logic [TONE_W-1:0] c;
		logic [TONE_W-1:0] m;
		logic [TONE_W-1:0] y;
		logic [TONE_W-1:0] k;
		logic [TONE_W-1:0] lc;
		logic [TONE_W-1:0] lm;
		logic              eoi;
	} tones_t;

	typedef struct {
		logic              enable;
		logic [TONE_W-1:0] gate;
		logic [TONE_W-1:0] max_tone;
		logic [TONE_W-1:0] strength;
		logic [TONE_W-1:0] gain;
		logic [TONE_W-1:0] black_floor;
		logic [PCT_W-1:0]  lc_pct;
		logic [PCT_W-1:0]  lm_pct;
	} gcr_setting_t;

	// settings mirror, gray replacement predictor and pending pixel queue
	class gcr_checker;
		gcr_setting_t set;
		tones_t       expected_tones[$];
		int           errors;
		int           reported;

		function new();
			set.enable      = 1'b0;
			set.gate        = 8'd14;
			set.max_tone    = 8'd180;
			set.strength    = 8'd160;
			set.gain        = 8'd220;
			set.black_floor = 8'd6;
			set.lc_pct      = 7'd70;
			set.lm_pct      = 7'd50;
			errors          = 0;
			reported        = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				REG_ENABLE:   set.enable      = v[0];
				REG_GATE:     set.gate        = v[TONE_W-1:0];
				REG_MAX_TONE: set.max_tone    = v[TONE_W-1:0];
				REG_STRENGTH: set.strength    = v[TONE_W-1:0];
				REG_GAIN:     set.gain        = v[TONE_W-1:0];
				REG_FLOOR:    set.black_floor = v[TONE_W-1:0];
				REG_LC_FADE:  set.lc_pct      = v[PCT_W-1:0];
				REG_LM_FADE:  set.lm_pct      = v[PCT_W-1:0];
				default: ;
			endcase
		endfunction

		// percent above full fades the ink away completely
		function logic [TONE_W-1:0] fade(logic [TONE_W-1:0] v, logic [PCT_W-1:0] pct);
			logic [PCT_W-1:0]    keep;
			logic [FADE_P_W-1:0] prod;
			keep = (pct > PCT_FULL) ? '0 : PCT_FULL - pct;
			prod = v * keep;
			return TONE_W'(prod / 15'd100);
		endfunction

		function tones_t replace_gray(tones_t p);
			tones_t              r;
			logic [TONE_W-1:0]   hi;
			logic [TONE_W-1:0]   lo;
			logic [TONE_W-1:0]   pull;
			logic [TONE_W-1:0]   add;
			logic [PROD_W-1:0]   prod;
			logic [TONE_W:0]     ksum;
			r  = p;
			hi = p.c;
			lo = p.c;
			if (p.m > hi) hi = p.m;
			if (p.y > hi) hi = p.y;
			if (p.m < lo) lo = p.m;
			if (p.y < lo) lo = p.y;
			if (set.enable && (hi - lo) <= set.gate && hi <= set.max_tone) begin
				prod = lo * set.strength;
				pull = TONE_W'(prod / 16'd255);
				r.c  = p.c - pull;
				r.m  = p.m - pull;
				r.y  = p.y - pull;
				prod = pull * set.gain;
				add  = TONE_W'(prod / 16'd255);
				ksum = {1'b0, p.k} + {1'b0, add};
				r.k  = ksum[TONE_W] ? 8'hFF : ksum[TONE_W-1:0];
				// a neutral pixel with any gray gets at least the black floor
				if (r.k < set.black_floor && lo != 0) r.k = set.black_floor;
				r.lc = fade(p.lc, set.lc_pct);
				r.lm = fade(p.lm, set.lm_pct);
			end
			return r;
		endfunction

		function void note_pixel(tones_t p);
			expected_tones.push_back(replace_gray(p));
		endfunction

		function int pending();
			return expected_tones.size();
		endfunction

		function void field(string name, logic [TONE_W-1:0] want, logic [TONE_W-1:0] got);
			if (want !== got) begin
				errors++;
				if (reported < REPORT_CAP) begin
					reported++;
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				end
			end
		endfunction

		function void check_pixel_out(tones_t got);
			tones_t want;
			if (expected_tones.size() == 0) begin
				errors++;
				if (reported < REPORT_CAP) begin
					reported++;
					$display("%0t: result with no item pending, expected none, got %h",
						$time, got);
				end
				return;
			end
			want = expected_tones.pop_front();
			field("cyan_out", want.c, got.c);
			field("magenta_out", want.m, got.m);
			field("yellow_out", want.y, got.y);
			field("black_out", want.k, got.k);
			field("light_cyan_out", want.lc, got.lc);
			field("light_magenta_out", want.lm, got.lm);
			field("end_of_image_out", {7'd0, want.eoi}, {7'd0, got.eoi});
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	tones_t            drive_px;
	logic              done;
	logic [TONE_W-1:0] cyan_out;
	logic [TONE_W-1:0] magenta_out;
	logic [TONE_W-1:0] yellow_out;
	logic [TONE_W-1:0] black_out;
	logic [TONE_W-1:0] light_cyan_out;
	logic [TONE_W-1:0] light_magenta_out;
	logic              end_of_image_out;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gcr_checker gray_sb;

	neutral_gcr_light_ink_fade u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cyan_in          (drive_px.c),
		.magenta_in       (drive_px.m),
		.yellow_in        (drive_px.y),
		.black_in         (drive_px.k),
		.light_cyan_in    (drive_px.lc),
		.light_magenta_in (drive_px.lm),
		.end_of_image     (drive_px.eoi),
		.done             (done),
		.cyan_out         (cyan_out),
		.magenta_out      (magenta_out),
		.yellow_out       (yellow_out),
		.black_out        (black_out),
		.light_cyan_out   (light_cyan_out),
		.light_magenta_out(light_magenta_out),
		.end_of_image_out (end_of_image_out),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// note accepted items and check strobed results
	always @(posedge clk) begin : pixel_monitor
		tones_t got;
		if (arst_n) begin
			if (start && !busy) gray_sb.note_pixel(drive_px);
			if (done) begin
				got = {cyan_out, magenta_out, yellow_out, black_out,
					light_cyan_out, light_magenta_out, end_of_image_out};
				gray_sb.check_pixel_out(got);
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) quiet = 0;
			else quiet++;
		end
		$display("neutral_gcr_light_ink_fade regression: fail");
		$finish;
	end

	function automatic tones_t px(int c, int m, int y, int k, int lc, int lm, bit eoi);
		tones_t p;
		p.c   = TONE_W'(c);
		p.m   = TONE_W'(m);
		p.y   = TONE_W'(y);
		p.k   = TONE_W'(k);
		p.lc  = TONE_W'(lc);
		p.lm  = TONE_W'(lm);
		p.eoi = eoi;
		return p;
	endfunction

	// apb write: setup then access, register taken when pready is high
	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		gray_sb.write_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// optionally set the unused upper data bits to random values
	function automatic logic [DATA_W-1:0] with_junk(logic [DATA_W-1:0] v, int w, bit junk);
		if (junk) return v | ($urandom << w);
		return v;
	endfunction

	task automatic write_setting(gcr_setting_t s, bit junk);
		apb_write(REG_ENABLE,   with_junk(DATA_W'(s.enable), 1, junk));
		apb_write(REG_GATE,     with_junk(DATA_W'(s.gate), TONE_W, junk));
		apb_write(REG_MAX_TONE, with_junk(DATA_W'(s.max_tone), TONE_W, junk));
		apb_write(REG_STRENGTH, with_junk(DATA_W'(s.strength), TONE_W, junk));
		apb_write(REG_GAIN,     with_junk(DATA_W'(s.gain), TONE_W, junk));
		apb_write(REG_FLOOR,    with_junk(DATA_W'(s.black_floor), TONE_W, junk));
		apb_write(REG_LC_FADE,  with_junk(DATA_W'(s.lc_pct), PCT_W, junk));
		apb_write(REG_LM_FADE,  with_junk(DATA_W'(s.lm_pct), PCT_W, junk));
	endtask

	// wait until every pending pixel is back
	task automatic wait_drained();
		do @(negedge clk); while (gray_sb.pending() != 0);
	endtask

	// drained and past the pipeline, safe for register writes
	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_pixel(tones_t p);
		start    <= 1'b1;
		drive_px <= p;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(int mode);
		int r;
		if (mode == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TONE_W-1:0] pick_byte(int low_hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'hFF;
		if (r < 6) return TONE_W'($urandom_range(0, low_hi));
		return TONE_W'($urandom);
	endfunction

	function automatic gcr_setting_t random_setting();
		gcr_setting_t s;
		s.enable      = ($urandom_range(0, 7) != 0);
		s.gate        = pick_byte(40);
		s.max_tone    = pick_byte(255);
		s.strength    = pick_byte(255);
		s.gain        = pick_byte(255);
		s.black_floor = pick_byte(60);
		s.lc_pct = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
			: PCT_W'($urandom_range(0, 100));
		s.lm_pct = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
			: PCT_W'($urandom_range(0, 100));
		return s;
	endfunction

	// near-neutral pixels dominate, then gate boundaries, then anything
	function automatic tones_t random_pixel();
		tones_t p;
		int     t [3];
		int     kind;
		int     lo;
		int     hi;
		int     sp;
		int     rot;
		kind  = $urandom_range(0, 99);
		p.k   = ($urandom_range(0, 2) == 0) ? TONE_W'($urandom_range(200, 255))
			: TONE_W'($urandom);
		p.lc  = TONE_W'($urandom);
		p.lm  = TONE_W'($urandom);
		p.eoi = ($urandom_range(0, 19) == 0);
		if (kind < 55) begin
			lo = $urandom_range(0, gray_sb.set.max_tone);
			for (int i = 0; i < 3; i++) begin
				t[i] = lo + $urandom_range(0, gray_sb.set.gate);
				if (t[i] > 255) t[i] = 255;
			end
		end else if (kind < 75) begin
			hi = gray_sb.set.max_tone + $urandom_range(0, 1);
			if (hi > 255) hi = 255;
			sp = gray_sb.set.gate + $urandom_range(0, 1);
			lo = hi - sp;
			if (lo < 0) lo = 0;
			t[0] = lo;
			t[1] = hi;
			t[2] = $urandom_range(lo, hi);
		end else begin
			for (int i = 0; i < 3; i++) t[i] = $urandom_range(0, 255);
			// zero neutral now and then
			if (kind < 82) t[$urandom_range(0, 2)] = 0;
		end
		rot = $urandom_range(0, 2);
		p.c = TONE_W'(t[rot]);
		p.m = TONE_W'(t[(rot + 1) % 3]);
		p.y = TONE_W'(t[(rot + 2) % 3]);
		return p;
	endfunction

	initial begin : stimulus
		gcr_setting_t s;
		int           items_left;
		int           n;
		int           mode;
		int           phase;
		gray_sb  = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		drive_px = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: disabled, everything passes through
		send_pixel(px(0, 0, 0, 0, 0, 0, 0));
		send_pixel(px(255, 255, 255, 255, 255, 255, 1));
		send_pixel(px(90, 90, 90, 0, 120, 120, 0));
		send_pixel(px(1, 1, 1, 0, 40, 40, 0));
		start <= 1'b0;
		settle();
		apb_write(REG_ENABLE, DATA_W'(1));

		// default settings enabled: gate, tone limit, floor and saturation corners
		send_pixel(px(0, 0, 0, 0, 255, 255, 0));
		send_pixel(px(180, 180, 180, 0, 100, 100, 0));
		send_pixel(px(181, 181, 181, 10, 200, 200, 0));
		send_pixel(px(100, 114, 107, 20, 50, 60, 0));
		send_pixel(px(100, 115, 107, 20, 50, 60, 0));
		send_pixel(px(170, 170, 170, 250, 1, 1, 0));
		send_pixel(px(1, 1, 1, 0, 0, 0, 0));
		send_pixel(px(255, 255, 255, 255, 255, 255, 1));
		send_pixel(px(0, 14, 7, 3, 128, 64, 1));
		start <= 1'b0;
		settle();

		// all maximum, fade percents above full
		s = '{enable: 1'b1, gate: 8'hFF, max_tone: 8'hFF, strength: 8'hFF, gain: 8'hFF,
			black_floor: 8'hFF, lc_pct: 7'd127, lm_pct: 7'd101};
		write_setting(s, 1'b0);
		send_pixel(px(255, 255, 255, 255, 255, 255, 1));
		send_pixel(px(0, 255, 128, 0, 255, 255, 0));
		send_pixel(px(1, 2, 3, 0, 170, 85, 0));
		send_pixel(px(0, 0, 0, 0, 255, 255, 0));
		start <= 1'b0;
		settle();

		// all minimum
		s = '{enable: 1'b1, gate: 8'd0, max_tone: 8'd0, strength: 8'd0, gain: 8'd0,
			black_floor: 8'd0, lc_pct: 7'd0, lm_pct: 7'd0};
		write_setting(s, 1'b0);
		send_pixel(px(0, 0, 0, 77, 255, 255, 0));
		send_pixel(px(0, 0, 1, 5, 9, 9, 1));
		send_pixel(px(1, 1, 1, 0, 255, 0, 0));
		start <= 1'b0;

		// random setting phases
		items_left = RANDOM_ITEMS;
		phase      = 0;
		while (items_left > 0) begin
			settle();
			write_setting(random_setting(), 1'($urandom_range(0, 1)));
			n = $urandom_range(60, 160);
			if (n > items_left) n = items_left;
			mode = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				send_pixel(random_pixel());
				if ((phase == 0 && i == 10) || $urandom_range(0, 149) == 0) begin
					// hold off until the pipeline is empty
					start <= 1'b0;
					wait_drained();
				end else begin
					idle_gap(pick_gap(mode));
				end
			end
			start <= 1'b0;
			items_left -= n;
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (gray_sb.errors == 0)
			$display("neutral_gcr_light_ink_fade regression: pass");
		else
			$display("neutral_gcr_light_ink_fade regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/nglif_pkg.sv
sv/nglif_cfg.sv
sv/nglif_detect.sv
sv/nglif_mix.sv
sv/neutral_gcr_light_ink_fade.sv
tb/tb_neutral_gcr_light_ink_fade.sv
